// File: hw/rtl/fxa_pkg.sv
package fxa_pkg;

   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_SUB     = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_DIV     = 4'd3;
   localparam logic [3:0] OP_MIN     = 4'd4;
   localparam logic [3:0] OP_MAX     = 4'd5;
   localparam logic [3:0] OP_INC     = 4'd6;
   localparam logic [3:0] OP_DEC     = 4'd7;
   localparam logic [3:0] OP_TOINT   = 4'd8;
   localparam logic [3:0] OP_FROMINT = 4'd9;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_raw;
      logic               a_greater;
      logic               a_less;
      logic               overflow_flag;
      logic               divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
      logic               a_greater;
      logic               a_less;
      logic               div_nonzero;
   } entry_type;

endpackage

// File: hw/rtl/fxa_front.sv
module fxa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fxa_pkg::req_type    req_data,
   output logic                out_valid,
   output fxa_pkg::entry_type  out_item,
   input  logic                out_ready
);

   logic               stage_valid_ff, stage_valid_in;
   fxa_pkg::entry_type item_ff, item_in;
   logic               advance, accept;

   assign advance = !stage_valid_ff || out_ready;
   assign busy    = !advance;
   assign accept  = start && advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (out_ready) begin
         stage_valid_in = 1'b0;
      end
      item_in             = item_ff;
      if (accept) begin
         item_in.operation   = req_data.operation;
         item_in.operand_a   = req_data.operand_a;
         item_in.operand_b   = req_data.operand_b;
         item_in.a_greater   = req_data.operand_a > req_data.operand_b;
         item_in.a_less      = req_data.operand_a < req_data.operand_b;
         item_in.div_nonzero = (req_data.operation == fxa_pkg::OP_DIV) &&
                               (req_data.operand_b != 32'sd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = stage_valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hw/rtl/fxa_queue.sv
module fxa_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fxa_pkg::entry_type  in_item,
   output logic                in_ready,
   output logic                out_valid,
   output fxa_pkg::entry_type  out_item,
   input  logic                out_ready
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   fxa_pkg::entry_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: hw/rtl/fxa_back.sv
module fxa_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fxa_pkg::entry_type  in_item,
   output logic                in_ready,
   output logic                rsp_valid,
   output fxa_pkg::rsp_type    rsp_data
);

   localparam int F  = FRAC_BITS;
   localparam int PWW = 2 * F + 2;
   localparam int DW = 32 + F;
   localparam int CW = $clog2(DW);

   logic pop, pop_div, pop_pipe;

   // execute stage inputs
   logic signed [31:0]    a, b;
   logic signed [32:0]    sum, diff, tadj, tsh;
   logic signed [31:0]    simple_res;
   logic                  simple_ovf, simple_dbz;
   logic [F-1:0]          la, lb;
   logic signed [F:0]     fa, fb;
   logic [F:0]            from_top;

   // stage one registers
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_mul_ff;
   logic signed [31:0]    s1_res_ff;
   logic                  s1_ovf_ff, s1_dbz_ff, s1_gt_ff, s1_lt_ff;
   logic signed [63:0]    s1_prod_ff;
   logic signed [PWW-1:0] s1_ff_ff;

   // multiply finish
   logic signed [PWW-1:0] ptr;
   logic signed [63:0]    mexact;
   logic                  movf;

   // divider
   logic                  div_busy_ff, div_busy_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DW-1:0]         quo_ff, quo_in, qneg;
   logic [31:0]           rem_ff, rem_in, den_ff, den_in, amag, bmag;
   logic [32:0]           trial;
   logic                  neg_ff, neg_in, dgt_ff, dgt_in, dlt_ff, dlt_in;
   logic                  div_done;

   logic                  rsp_valid_ff, rsp_valid_in;
   fxa_pkg::rsp_type      rsp_ff, rsp_in;

   assign in_ready = !div_busy_ff;
   assign pop      = in_valid && in_ready;
   assign pop_div  = pop && in_item.div_nonzero;
   assign pop_pipe = pop && !in_item.div_nonzero;

   assign a  = in_item.operand_a;
   assign b  = in_item.operand_b;
   assign la = a[F-1:0];
   assign lb = b[F-1:0];
   assign fa = (a[31] && (la != '0)) ? {1'b1, la} : {1'b0, la};
   assign fb = (b[31] && (lb != '0)) ? {1'b1, lb} : {1'b0, lb};
   assign sum      = {a[31], a} + {b[31], b};
   assign diff     = {a[31], a} - {b[31], b};
   assign tadj     = {a[31], a} + (a[31] ? 33'sd0 + 33'((1 << F) - 1) : 33'sd0);
   assign tsh      = tadj >>> F;
   assign from_top = a[31:31-F];

   always_comb begin
      simple_res = 32'sd0;
      simple_ovf = 1'b0;
      simple_dbz = 1'b0;
      unique case (in_item.operation)
         fxa_pkg::OP_ADD: begin
            simple_res = sum[31:0];
            simple_ovf = sum[32] != sum[31];
         end
         fxa_pkg::OP_SUB: begin
            simple_res = diff[31:0];
            simple_ovf = diff[32] != diff[31];
         end
         fxa_pkg::OP_DIV: begin
            simple_dbz = 1'b1;
         end
         fxa_pkg::OP_MIN: simple_res = in_item.a_less ? a : b;
         fxa_pkg::OP_MAX: simple_res = in_item.a_greater ? a : b;
         fxa_pkg::OP_INC: begin
            simple_res = a + 32'sd1;
            simple_ovf = a == 32'sh7fffffff;
         end
         fxa_pkg::OP_DEC: begin
            simple_res = a - 32'sd1;
            simple_ovf = a == 32'sh80000000;
         end
         fxa_pkg::OP_TOINT: simple_res = tsh[31:0];
         fxa_pkg::OP_FROMINT: begin
            simple_res = a <<< F;
            simple_ovf = !((&from_top) || (~|from_top));
         end
         default: simple_res = 32'sd0;
      endcase
   end

   assign s1_valid_in = pop_pipe;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (pop_pipe) begin
         s1_mul_ff  <= in_item.operation == fxa_pkg::OP_MUL;
         s1_res_ff  <= simple_res;
         s1_ovf_ff  <= simple_ovf;
         s1_dbz_ff  <= simple_dbz;
         s1_gt_ff   <= in_item.a_greater;
         s1_lt_ff   <= in_item.a_less;
         s1_prod_ff <= 64'(a) * 64'(b);
         s1_ff_ff   <= PWW'(fa) * PWW'(fb);
      end
   end

   assign ptr    = s1_ff_ff[PWW-1] ? -((-s1_ff_ff) >>> F) : (s1_ff_ff >>> F);
   assign mexact = ((s1_prod_ff - 64'(s1_ff_ff)) >>> F) + 64'(ptr);
   assign movf   = !((&mexact[63:31]) || (~|mexact[63:31]));

   assign amag  = a[31] ? 32'(-a) : 32'(a);
   assign bmag  = b[31] ? 32'(-b) : 32'(b);
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign div_done = div_busy_ff && (cnt_ff == '0);

   always_comb begin
      div_busy_in = div_busy_ff;
      cnt_in      = cnt_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      dgt_in      = dgt_ff;
      dlt_in      = dlt_ff;
      if (pop_div) begin
         div_busy_in = 1'b1;
         cnt_in      = CW'(DW - 1);
         quo_in      = {amag, F'(0)};
         rem_in      = '0;
         den_in      = bmag;
         neg_in      = a[31] ^ b[31];
         dgt_in      = in_item.a_greater;
         dlt_in      = in_item.a_less;
      end else if (div_busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (div_done) begin
            div_busy_in = 1'b0;
         end
      end
   end

   assign qneg = neg_ff ? -quo_in : quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else begin
         div_busy_ff <= div_busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      dgt_ff <= dgt_in;
      dlt_ff <= dlt_in;
   end

   always_comb begin
      rsp_valid_in = s1_valid_ff || div_done;
      rsp_in       = rsp_ff;
      if (div_done) begin
         rsp_in.result_raw     = qneg[31:0];
         rsp_in.a_greater      = dgt_ff;
         rsp_in.a_less         = dlt_ff;
         rsp_in.overflow_flag  = 1'b0;
         rsp_in.divide_by_zero = 1'b0;
      end else if (s1_valid_ff) begin
         rsp_in.result_raw     = s1_mul_ff ? mexact[31:0] : s1_res_ff;
         rsp_in.a_greater      = s1_gt_ff;
         rsp_in.a_less         = s1_lt_ff;
         rsp_in.overflow_flag  = s1_mul_ff ? movf : s1_ovf_ff;
         rsp_in.divide_by_zero = s1_dbz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && div_done))
      else $error("pipeline and divider finish together");
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.divide_by_zero |-> rsp_ff.result_raw == 32'sd0)
      else $error("divide by zero with nonzero result");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      pop_div |=> div_busy_ff && !s1_valid_in)
      else $error("divider did not start");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      div_done |=> !div_busy_ff && rsp_valid_ff)
      else $error("divider did not finish");

endmodule

// File: hw/rtl/fixed_point_q24_8_alu.sv
// Items pass the front register, queue, stage-one register or divider, then the rsp register.
// Throughput: one item per cycle for all operations but nonzero divide, while the divider is idle.
// A nonzero divide holds the execute side while the one-bit-per-cycle
// restoring divider runs; the queue absorbs items meanwhile.
// Reset empties the front stage and queue and idles the divider.
// The receiver cannot stall: each result is strobed for exactly one cycle.
module fixed_point_q24_8_alu #(
   parameter int FRAC_BITS   = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fxa_pkg::req_type  req_data,
   output logic              rsp_valid,
   output fxa_pkg::rsp_type  rsp_data
);

   logic               f_valid, f_ready, q_valid, q_ready;
   fxa_pkg::entry_type f_item, q_item;

   fxa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_ready (f_ready)
   );

   fxa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .in_ready  (f_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_ready (q_ready)
   );

   fxa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .in_ready  (q_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
